[design/mlfqfx_pkg.sv]
`default_nettype none

package mlfqfx_pkg;

  // operation codes carried in cmd
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_DECAY = 2'd1;
  localparam logic [1:0] CMD_PRIO  = 2'd2;

  // load average weights: 59/60 of the old value plus 1/60 of the sample
  localparam int LOAD_NUM = 59;
  localparam int LOAD_DEN = 60;

  // recent cpu shift for the priority formula (divide by 4)
  localparam int RC_SHIFT = 2;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[design/mlfq_fixed_point_scheduler_math.sv]
`default_nettype none

// channel | direction | handshake            | payload
// --------+-----------+----------------------+--------------------------------------------
// in      | input     | in_valid / in_stall  | cmd, ready_count, cpu_usage_in, nice_value
// out     | output    | out_valid / out_stall| load_avg_out, cpu_usage_out, priority_out
//
// load update (cmd 0) makes two passes through the shared 32x32 multiplier, then the
// load average write. recent cpu decay (cmd 1) waits on the restoring divider, which
// gives one quotient bit per cycle, then makes one multiplier pass. priority (cmd 2)
// is computed directly from the captured inputs. one transaction is in work at a time;
// in_stall stays high from accept until the result is loaded into the output register.
// a stalled result holds; the next item is taken while it waits.
// synchronous reset clears the load average, the sequencer and out_valid.

module mlfq_fixed_point_scheduler_math #(
  parameter int FRAC_BITS    = 14,
  parameter int PRIORITY_MAX = 63,
  parameter int PRIORITY_MIN = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [1:0]  cmd,
  input  wire logic        [15:0] ready_count,
  input  wire logic signed [31:0] cpu_usage_in,
  input  wire logic signed [5:0]  nice_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [31:0] load_avg_out,
  output logic signed      [31:0] cpu_usage_out,
  output logic             [5:0]  priority_out
);
  import mlfqfx_pkg::*;

  // fixed-point constants, all folded at elaboration
  localparam logic [31:0] ONE  = 32'(64'd1 << FRAC_BITS);
  localparam logic [31:0] C59  = 32'((64'(LOAD_NUM) * (64'd1 << FRAC_BITS)) / 64'(LOAD_DEN));
  localparam logic [31:0] C01  = 32'((64'd1 << FRAC_BITS) / 64'(LOAD_DEN));
  localparam logic [31:0] FMAX = 32'(64'(PRIORITY_MAX) << FRAC_BITS);
  localparam logic [63:0] RND  = (64'd1 << FRAC_BITS) - 64'd1;
  localparam logic signed [31:0] PMAX_S = 32'(PRIORITY_MAX);
  localparam logic signed [31:0] PMIN_S = 32'(PRIORITY_MIN);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_A    = 4'd1;
  localparam logic [3:0] S_MUL_B    = 4'd2;
  localparam logic [3:0] S_FIN0     = 4'd3;
  localparam logic [3:0] S_DIV_GO   = 4'd4;
  localparam logic [3:0] S_DIV_WAIT = 4'd5;
  localparam logic [3:0] S_MUL_C    = 4'd6;
  localparam logic [3:0] S_FIN1     = 4'd7;
  localparam logic [3:0] S_PRI      = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]         state;
  logic [3:0]         state_next;

  // captured transaction
  logic [15:0]        ready_r;
  logic [31:0]        rc_r;
  logic [5:0]         nice_r;

  // working registers
  logic [31:0]        load_average;
  logic signed [63:0] p;
  logic [31:0]        acc;
  logic [31:0]        coef;
  logic [31:0]        res_rc;
  logic [5:0]         res_pri;

  logic               accept;
  logic               out_free;

  // shared multiplier, product registered in p
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  logic [63:0]        p_adj;
  logic [31:0]        p_tr;

  // divider hookup
  logic               div_start;
  logic [31:0]        load_x2;
  logic [31:0]        div_den;
  logic               div_zero;
  logic [31:0]        div_q;
  div_stat_t          div_stat;

  // priority datapath
  logic [31:0]        nice_ext;
  logic [31:0]        nice_fx;
  logic [31:0]        nice_fx2;
  logic [31:0]        rc_adj;
  logic [31:0]        rc_q;
  logic [31:0]        pv;
  logic signed [31:0] pf;
  logic signed [31:0] pri_val;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL_A: begin
        mul_a = C59;
        mul_b = load_average;
      end
      S_MUL_B: begin
        mul_a = C01;
        mul_b = {16'd0, ready_r};
      end
      S_MUL_C: begin
        mul_a = coef;
        mul_b = rc_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divide by 2^FRAC_BITS rounding toward zero: bias negatives before the shift
  assign p_adj = p + (p[63] ? RND : 64'd0);
  assign p_tr  = p_adj[FRAC_BITS +: 32];

  // decay coefficient 2L / (2L + 1)
  assign load_x2   = load_average << 1;
  assign div_den   = load_x2 + ONE;
  assign div_zero  = (div_den == 32'd0);
  assign div_start = (state == S_DIV_GO);

  mlfqfx_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (load_x2),
    .divisor  (div_den),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // nice in fixed point, and twice that for the priority term
  assign nice_ext = {{26{nice_r[5]}}, nice_r};
  assign nice_fx  = nice_ext << FRAC_BITS;
  assign nice_fx2 = nice_ext << (FRAC_BITS + 1);

  // recent cpu / 4 rounded toward zero
  assign rc_adj = rc_r + {30'd0, {RC_SHIFT{rc_r[31]}}};
  assign rc_q   = {{RC_SHIFT{rc_adj[31]}}, rc_adj[31:RC_SHIFT]};

  // floor to integer, then clamp
  assign pv = FMAX - rc_q - nice_fx2;
  assign pf = $signed(pv) >>> FRAC_BITS;

  always_comb begin
    priority if (pf < PMIN_S) begin
      pri_val = PMIN_S;
    end else if (pf > PMAX_S) begin
      pri_val = PMAX_S;
    end else begin
      pri_val = pf;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_LOAD:  state_next = S_MUL_A;
            CMD_DECAY: state_next = S_DIV_GO;
            CMD_PRIO:  state_next = S_PRI;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_MUL_A:    state_next = S_MUL_B;
      S_MUL_B:    state_next = S_FIN0;
      S_FIN0:     state_next = S_DONE;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_stat.done) begin
          state_next = S_MUL_C;
        end
      end
      S_MUL_C:    state_next = S_FIN1;
      S_FIN1:     state_next = S_DONE;
      S_PRI:      state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      load_average <= '0;
    end else begin
      state <= state_next;
      if (state == S_FIN0) begin
        // new load = 59/60 * load + 1/60 * ready
        load_average <= acc + p[31:0];
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ready_r <= ready_count;
      rc_r    <= cpu_usage_in;
      nice_r  <= nice_value;
      res_rc  <= '0;
      res_pri <= '0;
    end
    if (state == S_MUL_A || state == S_MUL_B || state == S_MUL_C) begin
      p <= mul_p;
    end
    if (state == S_MUL_B) begin
      acc <= p_tr;
    end
    if (state == S_DIV_WAIT && div_stat.done) begin
      // wrapped divisor of zero gives a zero coefficient
      coef <= div_zero ? 32'd0 : div_q;
    end
    if (state == S_FIN1) begin
      res_rc <= p_tr + nice_fx;
    end
    if (state == S_PRI) begin
      res_pri <= pri_val[5:0];
    end
    if (state == S_DONE && out_free) begin
      load_avg_out  <= load_average;
      cpu_usage_out <= res_rc;
      priority_out  <= res_pri;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken again right after a transaction");
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV_WAIT))
    else $error("divider finished outside its wait state");
  a_load_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (state != S_FIN0) |=> $stable(load_average))
    else $error("load average changed outside the update step");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");

endmodule

`default_nettype wire

[design/mlfqfx_div.sv]
`default_nettype none

module mlfqfx_div #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [31:0]             dividend,
  input  wire logic [31:0]             divisor,
  output mlfqfx_pkg::div_stat_t        stat,
  output logic      [31:0]             quotient
);
  import mlfqfx_pkg::*;

  // dividend magnitude is pre-scaled by 2^FRAC_BITS
  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW);

  logic [31:0]   dd_mag;
  logic [31:0]   dv_mag;
  logic [31:0]   rem;
  logic [NW-1:0] quo;
  logic [31:0]   dmag;
  logic          neg;
  logic [CW-1:0] count;
  logic          running;
  logic          done;
  logic [32:0]   rem_sh;
  logic [32:0]   diff;
  logic          ge;

  assign dd_mag = dividend[31] ? (~dividend + 32'd1) : dividend;
  assign dv_mag = divisor[31] ? (~divisor + 32'd1) : divisor;

  // one restoring step per cycle
  assign rem_sh = {rem, quo[NW-1]};
  assign diff   = rem_sh - {1'b0, dmag};
  assign ge     = ~diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + 1'b1;
        if (count == CW'(NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= {dd_mag, {FRAC_BITS{1'b0}}};
      dmag <= dv_mag;
      neg  <= dividend[31] ^ divisor[31];
    end else if (running) begin
      rem <= ge ? diff[31:0] : rem_sh[31:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

  // truncate toward zero, keep the low 32 bits
  assign quotient  = neg ? (~quo[31:0] + 32'd1) : quo[31:0];
  assign stat.busy = running;
  assign stat.done = done;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !running)
    else $error("divider started while busy");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst) done |-> !running)
    else $error("divider done while still busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

[tb/tb_mlfq_fixed_point_scheduler_math.sv]
`timescale 1ns / 100ps

module tb_mlfq_fixed_point_scheduler_math;
  import mlfqfx_pkg::*;

  localparam int FRAC_BITS    = 14;
  localparam int PRIORITY_MAX = 63;
  localparam int PRIORITY_MIN = 0;

  // code with no operation behind it: the block only reports the load average
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam longint FX_ONE  = longint'(1) << FRAC_BITS;
  localparam longint FX_C59  = (LOAD_NUM * FX_ONE) / LOAD_DEN;
  localparam longint FX_C01  = FX_ONE / LOAD_DEN;

  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 60;     // decay is the slowest command
  localparam int IDLE_LIMIT   = 4000;   // cycles with no transaction on either side
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off

  typedef struct {
    logic        [1:0]  cmd;
    logic        [15:0] ready;
    logic signed [31:0] rc;
    logic signed [5:0]  nice;
    bit                 typed;   // expected result written into the row by hand
    logic signed [31:0] e_load;
    logic signed [31:0] e_rc;
    logic        [5:0]  e_pri;
  } sched_item_t;

  typedef struct {
    logic signed [31:0] load;
    logic signed [31:0] rc;
    logic        [5:0]  pri;
  } sched_res_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic        [1:0]   cmd = '0;
  logic        [15:0]  ready_count = '0;
  logic signed [31:0]  cpu_usage_in = '0;
  logic signed [5:0]   nice_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic signed [31:0]  load_avg_out;
  logic signed [31:0]  cpu_usage_out;
  logic        [5:0]   priority_out;

  mlfq_fixed_point_scheduler_math #(
    .FRAC_BITS   (FRAC_BITS),
    .PRIORITY_MAX(PRIORITY_MAX),
    .PRIORITY_MIN(PRIORITY_MIN)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .ready_count  (ready_count),
    .cpu_usage_in (cpu_usage_in),
    .nice_value   (nice_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .load_avg_out (load_avg_out),
    .cpu_usage_out(cpu_usage_out),
    .priority_out (priority_out)
  );

  always #2 clk = ~clk;

  sched_item_t stim_q[$];        // directed rows first, then the random part
  sched_res_t  results_due[$];   // expected results in acceptance order
  logic signed [31:0] pred_load = '0;  // predicted load average

  int  send_idx     = 0;
  int  results_seen = 0;
  int  error_count  = 0;
  logic hold_off    = 1'b0;

  // predicted effect of one input transaction on the load average and the result
  function automatic sched_res_t sched_math_step(sched_item_t it);
    sched_res_t r;
    logic signed [31:0] f0, f1, two_l, den, coef, term, fmax, r4, n2, v;
    longint p;
    r.load = '0;
    r.rc   = '0;
    r.pri  = '0;
    case (it.cmd)
      CMD_LOAD: begin
        // 59/60 of the old load plus 1/60 of the ready count, truncated
        f0 = 32'((FX_C59 * longint'(pred_load)) / FX_ONE);
        f1 = 32'(FX_C01 * longint'(it.ready));
        pred_load = f0 + f1;
      end
      CMD_DECAY: begin
        two_l = pred_load * 2;
        den   = two_l + 32'(FX_ONE);
        // a divisor that wraps to zero gives a zero coefficient
        if (den == 0) coef = '0;
        else coef = 32'((longint'(two_l) * FX_ONE) / longint'(den));
        term = 32'((longint'(coef) * longint'(it.rc)) / FX_ONE);
        r.rc = term + 32'(longint'(it.nice) * FX_ONE);
      end
      CMD_PRIO: begin
        fmax = 32'(longint'(PRIORITY_MAX) * FX_ONE);
        r4   = 32'(longint'(it.rc) / (longint'(1) << RC_SHIFT));
        n2   = 32'(longint'(it.nice) * 2 * FX_ONE);
        v    = fmax - r4 - n2;
        p    = longint'(v) >>> FRAC_BITS;   // floor
        if (p < PRIORITY_MIN) p = PRIORITY_MIN;
        else if (p > PRIORITY_MAX) p = PRIORITY_MAX;
        r.pri = p[5:0];
      end
      default: ;  // unknown code leaves the state alone
    endcase
    r.load = pred_load;
    return r;
  endfunction

  function automatic void add_row(logic [1:0] c, logic [15:0] rdy, logic signed [31:0] rc,
                                  logic signed [5:0] nc, bit typed = 1'b0,
                                  logic signed [31:0] e_load = '0,
                                  logic signed [31:0] e_rc = '0, logic [5:0] e_pri = '0);
    sched_item_t it;
    it.cmd    = c;
    it.ready  = rdy;
    it.rc     = rc;
    it.nice   = nc;
    it.typed  = typed;
    it.e_load = e_load;
    it.e_rc   = e_rc;
    it.e_pri  = e_pri;
    stim_q.push_back(it);
  endfunction

  // stimulus: directed table, then random segments
  initial begin
    int seg_kind, seg_left, n, pick;
    logic [1:0]  c;
    logic [15:0] rdy;
    logic signed [31:0] rc;

    // directed rows, load average is zero right after reset
    add_row(CMD_PRIO,  16'd0,     32'sd0,             6'sd0,   1'b1, 0, 0, 6'd63);
    add_row(CMD_DECAY, 16'd0,     32'sh7FFF_FFFF,     -6'sd20, 1'b1, 0, -32'sd327680, 0);
    add_row(CMD_DECAY, 16'd0,     32'sh8000_0000,     6'sd20,  1'b1, 0, 32'sd327680, 0);
    add_row(CMD_NONE,  16'hFFFF,  -32'sd1,            -6'sd1,  1'b1, 0, 0, 0);
    // priority clamps at both ends
    add_row(CMD_PRIO,  16'hFFFF,  32'sh7FFF_FFFF,     6'sd20,  1'b1, 0, 0, 6'd0);
    add_row(CMD_PRIO,  16'd0,     32'sh8000_0000,     -6'sd20, 1'b1, 0, 0, 6'd63);
    add_row(CMD_LOAD,  16'd0,     32'sd0,             6'sd0,   1'b1, 0, 0, 0);
    add_row(CMD_LOAD,  16'hFFFF,  32'sd0,             6'sd0,   1'b1, 32'sd17891055, 0, 0);
    // from here on the load average is nonzero
    add_row(CMD_DECAY, 16'd0,     32'sh7FFF_FFFF,     6'sd20);
    add_row(CMD_DECAY, 16'd0,     32'sh8000_0000,     -6'sd20);
    add_row(CMD_LOAD,  16'hFFFF,  32'sd0,             6'sd0);
    add_row(CMD_LOAD,  16'h5555,  32'sh5555_5555,     6'sd10);
    add_row(CMD_PRIO,  16'd0,     32'sh0004_0000,     6'sd0);
    add_row(CMD_PRIO,  16'd0,     -32'sd1,            6'sd0);   // quarter truncates to zero
    add_row(CMD_PRIO,  16'd0,     32'sd3,             6'sd0);
    add_row(CMD_PRIO,  16'd0,     32'sd0,             6'sd1);
    add_row(CMD_PRIO,  16'd0,     32'sd0,             -6'sd1);  // just over the top
    add_row(CMD_NONE,  16'h0000,  32'sh7FFF_FFFF,     6'sd20);
    add_row(CMD_DECAY, 16'hAAAA,  32'sd16384,         6'sd0);
    add_row(CMD_LOAD,  16'd1,     -32'sd16384,        -6'sd20);
    add_row(CMD_DECAY, 16'd0,     32'sh0123_4567,     6'sd13);

    // random part in segments that push the load up, let it decay, or mix
    seg_left = 0;
    seg_kind = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (seg_left == 0) begin
        seg_kind = $urandom_range(0, 2);
        seg_left = $urandom_range(50, 250);
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      if (pick < 30) c = CMD_LOAD;
      else if (pick < 60) c = CMD_DECAY;
      else if (pick < 92) c = CMD_PRIO;
      else c = CMD_NONE;
      case (seg_kind)
        0: rdy = ($urandom_range(0, 9) < 8) ? 16'hFFFF - 16'($urandom_range(0, 15))
                                            : 16'($urandom);
        1: rdy = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        default: rdy = 16'($urandom);
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 40) rc = 32'($urandom);
      else if (pick < 60) rc = 32'($urandom_range(0, 1 << 21)) - 32'sd1048576;
      else if (pick < 75) begin
        case ($urandom_range(0, 3))
          0: rc = 32'sh7FFF_FFFF;
          1: rc = 32'sh8000_0000;
          2: rc = 32'sd0;
          default: rc = -32'sd1;
        endcase
      end else rc = 32'($urandom_range(0, 200 << FRAC_BITS)) - (32'sd100 <<< FRAC_BITS);
      n = $urandom_range(0, 40) - 20;
      add_row(c, rdy, rc, n[5:0]);
    end
  end

  // sender: bursts of random length with random gaps in between
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin
    int pick;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        // transaction accepted at this edge: record what must come out
        if (stim_q[send_idx].typed) begin
          sched_res_t k;
          void'(sched_math_step(stim_q[send_idx]));  // keep the predicted state in step
          k.load = stim_q[send_idx].e_load;
          k.rc   = stim_q[send_idx].e_rc;
          k.pri  = stim_q[send_idx].e_pri;
          results_due.push_back(k);
        end else begin
          results_due.push_back(sched_math_step(stim_q[send_idx]));
        end
        send_idx++;
      end
      // payload may only change when nothing is offered or the offer was taken
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (send_idx < stim_q.size()) begin
          in_valid     <= 1'b1;
          cmd          <= stim_q[send_idx].cmd;
          ready_count  <= stim_q[send_idx].ready;
          cpu_usage_in <= stim_q[send_idx].rc;
          nice_value   <= stim_q[send_idx].nice;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) gap_left = $urandom_range(0, 3);
            else if (pick < 90) gap_left = $urandom_range(4, 60);
            else gap_left = 0;
            // now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, switching mode at random intervals
  int stall_mode = 0;
  int mode_left  = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    logic pat;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 300);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
        0: pat = 1'b0;                                  // no stall at all
        1: pat = ($urandom_range(0, 2) == 0);           // light
        2: pat = ($urandom_range(0, 3) != 0);           // heavy
        default: pat = ((stall_tick % 7) < 3);          // periodic
      endcase
      out_stall <= hold_off | pat;
    end
  end

  // one long hold-off while the sender keeps offering, so the input stalls
  initial begin
    wait (results_seen >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    sched_res_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (results_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result load=%0d rc=%0d pri=%0d", $time,
                 load_avg_out, cpu_usage_out, priority_out);
      end else begin
        e = results_due.pop_front();
        if (load_avg_out !== e.load) begin
          error_count++;
          $display("%0t: load_avg_out expected %0d actual %0d", $time, e.load, load_avg_out);
        end
        if (cpu_usage_out !== e.rc) begin
          error_count++;
          $display("%0t: cpu_usage_out expected %0d actual %0d", $time, e.rc,
                   cpu_usage_out);
        end
        if (priority_out !== e.pri) begin
          error_count++;
          $display("%0t: priority_out expected %0d actual %0d", $time, e.pri, priority_out);
        end
      end
    end
  end

  // watchdog: too long with no transaction on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, results_due.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // reset, then wait for the stimulus to drain
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (send_idx < stim_q.size()) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[mlfq_fixed_point_scheduler_math.f]
design/mlfqfx_pkg.sv
design/mlfqfx_div.sv
design/mlfq_fixed_point_scheduler_math.sv
tb/tb_mlfq_fixed_point_scheduler_math.sv
